FILE: hdl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held low.
`define CRDF_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("check failed");

// Next-cycle implication, disabled while reset is held low.
`define CRDF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("check failed");

`endif

FILE: hdl/crdf_pkg.sv
package crdf_pkg;

    localparam int HEADER_BYTES = 10;
    localparam int MAX_WIDTH    = 4096;

    localparam int CFG_DATA_W = 13;  // widest register: image_width
    localparam int HDR_W      = 4;
    localparam int LIT_W      = 7;
    localparam int RUN_W      = 8;

    // register indexes
    localparam logic CFG_IMAGE_WIDTH    = 1'b0;
    localparam logic CFG_HEADER_PRESENT = 1'b1;

    // operation codes on s_tuser
    localparam logic OP_FEED = 1'b0;
    localparam logic OP_READ = 1'b1;

    // result status codes
    localparam logic [1:0] RES_OK       = 2'd0;
    localparam logic [1:0] RES_NO_IMAGE = 2'd1;
    localparam logic [1:0] RES_OVERFLOW = 2'd2;

    localparam logic [CFG_DATA_W-1:0] WIDTH_RESET = 13'd64;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FEED,
        S_ZRUN,
        S_RD_POS,
        S_RD_DIV,
        S_RD_ADDR,
        S_RD_DATA
    } crdf_state_t;

    typedef struct packed {
        logic accept;
        logic feed;
        logic zrun;
        logic div_start;
        logic rd_pos;
        logic rd_addr;
        logic load_empty;
        logic load_pixel;
    } crdf_cmd_t;

    typedef struct packed {
        logic zrun_start;
        logic zrun_last;
        logic div_done;
        logic height_valid;
        logic no_image;
        logic out_busy;
    } crdf_stat_t;

endpackage

FILE: hdl/crdf_ram.sv
module crdf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: hdl/crdf_div.sv
// Restoring divider, one quotient bit per cycle.
module crdf_div #(
    parameter int NW = 17,
    parameter int DW = 13
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quot
);

    localparam int CNTW = $clog2(NW + 1);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [NW-1:0]   shf_reg, shf_next;
    logic [DW:0]     rem_reg, rem_next;
    logic [DW:0]     rem_sh;
    logic            ge;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        shf_next  = shf_reg;
        rem_next  = rem_reg;
        rem_sh    = {rem_reg[DW-1:0], shf_reg[NW-1]};
        ge        = (rem_sh >= {1'b0, den});
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNTW'(NW);
            shf_next  = num;
            rem_next  = '0;
        end else if (busy_reg) begin
            rem_next = ge ? (rem_sh - {1'b0, den}) : rem_sh;
            shf_next = {shf_reg[NW-2:0], ge};
            cnt_next = cnt_reg - CNTW'(1);
            if (cnt_reg == CNTW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        shf_reg <= shf_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign quot = shf_reg;

endmodule

FILE: hdl/crdf_datapath.sv
module crdf_datapath #(
    parameter int MAX_PIXELS = 65536
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [7:0]                     s_tdata,
    input  logic                           s_tlast,
    input  logic                           cfg_we,
    input  logic                           cfg_index,
    input  logic [crdf_pkg::CFG_DATA_W-1:0] cfg_data,
    input  crdf_pkg::crdf_cmd_t            cmd,
    output crdf_pkg::crdf_stat_t           stat,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [7:0]                     m_tdata,
    output logic                           m_tlast,
    output logic [2:0]                     m_tuser
);

    import crdf_pkg::*;

    localparam int AW  = $clog2(MAX_PIXELS);
    localparam int PCW = $clog2(MAX_PIXELS + 1);
    localparam int WW  = CFG_DATA_W;

    // item and configuration state
    logic [7:0]      byte_reg, byte_next;
    logic            last_reg, last_next;
    logic [WW-1:0]   width_reg, width_next;
    logic            hdr_en_reg, hdr_en_next;

    // decoder state
    logic            open_reg, open_next;
    logic            ready_reg, ready_next;
    logic            ovf_reg, ovf_next;
    logic [PCW-1:0]  pc_reg, pc_next;
    logic [HDR_W-1:0] hl_reg, hl_next;
    logic [LIT_W-1:0] lit_reg, lit_next;
    logic [RUN_W-1:0] run_reg, run_next;

    // read side
    logic [PCW-1:0]  row_reg, row_next;
    logic [WW-1:0]   col_reg, col_next;
    logic [PCW-1:0]  height_reg, height_next;
    logic            hv_reg, hv_next;
    logic [AW-1:0]   prod_reg, prod_next;

    // result register
    logic            ov_reg, ov_next;
    logic [7:0]      opx_reg, opx_next;
    logic            olast_reg, olast_next;
    logic            otr_reg, otr_next;
    logic [1:0]      ost_reg, ost_next;

    // combinational helpers
    logic [HDR_W-1:0] hdr_load, hl_eff;
    logic [LIT_W-1:0] lit_eff;
    logic [PCW-1:0]   pc_eff, put_pc;
    logic             ovf_eff;
    logic             put_en;
    logic [7:0]       put_val;
    logic             ram_we, ram_re;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    logic [7:0]       ram_wdata, ram_rdata;
    logic             wrap;
    logic [PCW-1:0]   row_eff, row_flip;
    logic [WW-1:0]    col_eff;
    logic [PCW+WW-1:0] prod_full;
    logic [AW+WW-1:0] addr_sum;
    logic [WW:0]      col_inc;
    logic [PCW:0]     row_inc;
    logic             last_hit;
    logic             width_ok;
    logic             div_done;
    logic [PCW-1:0]   div_quot;

    crdf_ram #(
        .WIDTH(8),
        .DEPTH(MAX_PIXELS)
    ) u_store (
        .clk  (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    crdf_div #(
        .NW(PCW),
        .DW(WW)
    ) u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (cmd.div_start),
        .num    (pc_reg),
        .den    (width_reg),
        .done   (div_done),
        .quot   (div_quot)
    );

    always_comb begin
        hdr_load = hdr_en_reg ? HDR_W'(HEADER_BYTES) : '0;
        hl_eff   = open_reg ? hl_reg  : hdr_load;
        lit_eff  = open_reg ? lit_reg : '0;
        pc_eff   = open_reg ? pc_reg  : '0;
        ovf_eff  = open_reg ? ovf_reg : 1'b0;
        width_ok = (width_reg != '0) && (width_reg <= WW'(MAX_WIDTH));

        wrap      = (row_reg >= height_reg) || (col_reg >= width_reg);
        row_eff   = wrap ? '0 : row_reg;
        col_eff   = wrap ? '0 : col_reg;
        row_flip  = height_reg - PCW'(1) - row_eff;
        prod_full = row_flip * width_reg;
        addr_sum  = {{WW{1'b0}}, prod_reg} + {{AW{1'b0}}, col_reg};
        col_inc   = {1'b0, col_reg} + (WW+1)'(1);
        row_inc   = {1'b0, row_reg} + (PCW+1)'(1);
        last_hit  = (row_reg == height_reg - PCW'(1)) && (col_reg == width_reg - WW'(1));
    end

    always_comb begin
        byte_next   = byte_reg;
        last_next   = last_reg;
        width_next  = width_reg;
        hdr_en_next = hdr_en_reg;
        open_next   = open_reg;
        ready_next  = ready_reg;
        ovf_next    = ovf_reg;
        pc_next     = pc_reg;
        hl_next     = hl_reg;
        lit_next    = lit_reg;
        run_next    = run_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        height_next = height_reg;
        hv_next     = hv_reg;
        prod_next   = prod_reg;
        ov_next     = ov_reg;
        opx_next    = opx_reg;
        olast_next  = olast_reg;
        otr_next    = otr_reg;
        ost_next    = ost_reg;
        put_en      = 1'b0;
        put_val     = byte_reg;
        put_pc      = cmd.feed ? pc_eff : pc_reg;
        ram_we      = 1'b0;
        ram_waddr   = put_pc[AW-1:0];
        ram_wdata   = put_val;
        ram_re      = 1'b0;
        ram_raddr   = addr_sum[AW-1:0];

        if (cmd.accept) begin
            byte_next = s_tdata;
            last_next = s_tlast;
        end

        if (cfg_we) begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH: begin
                    width_next = cfg_data;
                    hv_next    = 1'b0;
                end
                CFG_HEADER_PRESENT: hdr_en_next = cfg_data[0];
                default: ;
            endcase
        end

        if (cmd.feed) begin
            // the first byte of a stream also starts a new image
            open_next = 1'b1;
            hv_next   = 1'b0;
            hl_next   = hl_eff;
            lit_next  = lit_eff;
            pc_next   = pc_eff;
            ovf_next  = ovf_eff;
            if (!open_reg) begin
                ready_next = 1'b0;
                row_next   = '0;
                col_next   = '0;
            end
            if (hl_eff != '0) begin
                hl_next = hl_eff - HDR_W'(1);
            end else if (lit_eff != '0) begin
                put_en   = 1'b1;
                lit_next = lit_eff - LIT_W'(1);
            end else if (byte_reg[7]) begin
                run_next = (~byte_reg) + RUN_W'(1);  // 256 - byte
            end else begin
                lit_next = byte_reg[LIT_W-1:0];
            end
            if (last_reg) begin
                open_next  = 1'b0;
                ready_next = 1'b1;
                lit_next   = '0;
                hl_next    = '0;
            end
        end

        if (cmd.zrun) begin
            put_en   = 1'b1;
            put_val  = 8'd0;
            run_next = run_reg - RUN_W'(1);
        end

        ram_wdata = put_val;
        if (put_en) begin
            if (put_pc < PCW'(MAX_PIXELS)) begin
                ram_we  = 1'b1;
                pc_next = put_pc + PCW'(1);
            end else begin
                ovf_next = 1'b1;
            end
        end

        if (div_done) begin
            height_next = width_ok ? div_quot : '0;
            hv_next     = 1'b1;
        end

        if (cmd.rd_pos) begin
            row_next  = row_eff;
            col_next  = col_eff;
            prod_next = prod_full[AW-1:0];
        end

        if (cmd.rd_addr) begin
            ram_re = 1'b1;
        end

        if (cmd.load_empty) begin
            ov_next    = 1'b1;
            opx_next   = 8'd0;
            otr_next   = 1'b0;
            olast_next = 1'b0;
            ost_next   = RES_NO_IMAGE;
        end else if (cmd.load_pixel) begin
            ov_next    = 1'b1;
            opx_next   = ram_rdata;
            otr_next   = (ram_rdata == 8'd0);
            olast_next = last_hit;
            ost_next   = ovf_reg ? RES_OVERFLOW : RES_OK;
            if (col_inc >= {1'b0, width_reg}) begin
                col_next = '0;
                row_next = (row_inc >= {1'b0, height_reg}) ? '0 : row_inc[PCW-1:0];
            end else begin
                col_next = col_inc[WW-1:0];
            end
        end else if (m_tready) begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            hdr_en_reg <= 1'b0;
            open_reg   <= 1'b0;
            ready_reg  <= 1'b0;
            ovf_reg    <= 1'b0;
            pc_reg     <= '0;
            hl_reg     <= '0;
            lit_reg    <= '0;
            run_reg    <= '0;
            row_reg    <= '0;
            col_reg    <= '0;
            hv_reg     <= 1'b0;
            ov_reg     <= 1'b0;
        end else begin
            width_reg  <= width_next;
            hdr_en_reg <= hdr_en_next;
            open_reg   <= open_next;
            ready_reg  <= ready_next;
            ovf_reg    <= ovf_next;
            pc_reg     <= pc_next;
            hl_reg     <= hl_next;
            lit_reg    <= lit_next;
            run_reg    <= run_next;
            row_reg    <= row_next;
            col_reg    <= col_next;
            hv_reg     <= hv_next;
            ov_reg     <= ov_next;
        end
        byte_reg   <= byte_next;
        last_reg   <= last_next;
        height_reg <= height_next;
        prod_reg   <= prod_next;
        opx_reg    <= opx_next;
        olast_reg  <= olast_next;
        otr_reg    <= otr_next;
        ost_reg    <= ost_next;
    end

    always_comb begin
        stat.zrun_start   = (hl_eff == '0) && (lit_eff == '0) && byte_reg[7];
        stat.zrun_last    = (run_reg == RUN_W'(1));
        stat.div_done     = div_done;
        stat.height_valid = hv_reg;
        stat.no_image     = !ready_reg || (height_reg == '0);
        stat.out_busy     = ov_reg && !m_tready;
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = opx_reg;
    assign m_tlast  = olast_reg;
    assign m_tuser  = {ost_reg, otr_reg};

endmodule

FILE: hdl/crdf_ctrl.sv
module crdf_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tuser,
    output logic                 s_tready,
    input  crdf_pkg::crdf_stat_t stat,
    output crdf_pkg::crdf_cmd_t  cmd
);

    import crdf_pkg::*;

    crdf_state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = (s_tuser == OP_READ) ? S_RD_POS : S_FEED;
                end
            end
            S_FEED:    state_next = stat.zrun_start ? S_ZRUN : S_IDLE;
            S_ZRUN:    state_next = stat.zrun_last ? S_IDLE : S_ZRUN;
            S_RD_POS: begin
                if (!stat.height_valid) begin
                    state_next = S_RD_DIV;
                end else if (stat.no_image) begin
                    state_next = stat.out_busy ? S_RD_POS : S_IDLE;
                end else begin
                    state_next = S_RD_ADDR;
                end
            end
            S_RD_DIV:  state_next = stat.div_done ? S_RD_POS : S_RD_DIV;
            S_RD_ADDR: state_next = S_RD_DATA;
            S_RD_DATA: state_next = stat.out_busy ? S_RD_DATA : S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            S_FEED: cmd.feed = 1'b1;
            S_ZRUN: cmd.zrun = 1'b1;
            S_RD_POS: begin
                if (!stat.height_valid) begin
                    cmd.div_start = 1'b1;
                end else if (stat.no_image) begin
                    cmd.load_empty = !stat.out_busy;
                end else begin
                    cmd.rd_pos = 1'b1;
                end
            end
            S_RD_DIV:  ;
            S_RD_ADDR: cmd.rd_addr = 1'b1;
            S_RD_DATA: cmd.load_pixel = !stat.out_busy;
            default:   ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: hdl/cel_rle_decode_flip_unit.sv
// CEL run-length decoder with vertical flip.
// Input stream: s_tuser selects the operation (0 feeds the byte in s_tdata,
// s_tlast marking the final byte of the data; 1 requests the next pixel).
// Output stream: one transfer per pixel request; m_tdata is the palette index,
// m_tuser carries the transparent flag and a status code, m_tlast marks the
// last pixel of the bottom-to-top image. Feeds produce no output. Registers
// are written through cfg_we/cfg_index/cfg_data; the user is to write them
// only while idle, unchecked by the block. A literal, header or control byte
// passes the accept and feed states; a transparent run byte stays in the
// zero-run state for its n zeros (one store write per cycle). A pixel request
// passes the position, address and data states; the first request after new
// data or a width change runs the row-count divider first. The frame store
// has one write port, so decoding runs one pixel per cycle at best. Reset
// clears all control state; the frame store is not cleared and needs no
// clearing pass. A result waits in the output register while m_tready is
// low; byte feeds are still taken meanwhile, a further request waits.
module cel_rle_decode_flip_unit #(
    parameter int MAX_PIXELS = 65536
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // cel_byte
    input  logic                           s_tlast,   // last_byte
    input  logic                           s_tuser,   // operation
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [7:0]                     m_tdata,   // pixel_index
    output logic                           m_tlast,   // last_pixel
    output logic [2:0]                     m_tuser,   // status[1:0], is_transparent
    input  logic                           cfg_we,
    input  logic                           cfg_index,
    input  logic [crdf_pkg::CFG_DATA_W-1:0] cfg_data
);

    import crdf_pkg::*;

    crdf_cmd_t  cmd;
    crdf_stat_t stat;

    crdf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tuser (s_tuser),
        .s_tready(s_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    crdf_datapath #(
        .MAX_PIXELS(MAX_PIXELS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

FILE: hdl/crdf_checker.sv
`include "assert_macros.svh"

module crdf_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [7:0]                     s_tdata,
    input logic                           s_tlast,
    input logic                           s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [7:0]                     m_tdata,
    input logic                           m_tlast,
    input logic [2:0]                     m_tuser,
    input logic                           cfg_we,
    input logic                           cfg_index,
    input logic [crdf_pkg::CFG_DATA_W-1:0] cfg_data
);

    import crdf_pkg::*;

    // a pixel with a real status carries a transparent flag that matches it
    `CRDF_ASSERT_NOW(a_transp_flag, aclk, aresetn, m_tvalid && (m_tuser[2:1] != RES_NO_IMAGE), m_tuser[0] == (m_tdata == 8'd0))

    `CRDF_ASSERT_NOW(a_status_code, aclk, aresetn, m_tvalid, m_tuser[2:1] != 2'd3)

    // an empty-image answer is all zero apart from its status
    `CRDF_ASSERT_NOW(a_empty_result, aclk, aresetn, m_tvalid && (m_tuser[2:1] == RES_NO_IMAGE), (m_tdata == 8'd0) && !m_tlast && !m_tuser[0])

    // one item at a time: no transfer in the cycle after one
    `CRDF_ASSERT_NEXT(a_one_item, aclk, aresetn, s_tvalid && s_tready, !s_tready)

    `CRDF_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

endmodule

bind cel_rle_decode_flip_unit crdf_checker u_checker (.*);
